// File: src/match_length_run_cache_unit_macros.svh
// assertion macros shared by the match length run cache unit
`ifndef MATCH_LENGTH_RUN_CACHE_UNIT_MACROS_SVH
`define MATCH_LENGTH_RUN_CACHE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlrc assertion failed");

// next-cycle implication, checked outside reset
`define MLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlrc assertion failed");

`endif

// File: src/mlrc_pkg.sv
package mlrc_pkg;

    localparam int DEF_POSITIONS = 4096;
    localparam int DEF_SLOTS     = 8;

    localparam int POS_W  = 12;
    localparam int LEN_W  = 9;
    localparam int DIST_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic run_restart;
        logic put_prev;
        logic put_cur;
        logic set_prev;
        logic wr_last_len;
        logic clr_max;
        logic rd_head;
        logic latch_max;
        logic rd_first;
        logic walk_adv;
        logic load_nf;
        logic load_run;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_fetch;
        logic pos_ok;
        logic st_ok;
        logic elem_min;
        logic elem_full;
        logic dist_diff;
        logic run_full;
        logic su_full;
        logic su_last;
        logic head_nf;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

// File: src/mlrc_ctrl.sv
module mlrc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mlrc_pkg::t_sts i_sts,
    output mlrc_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import mlrc_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ST1    = 4'd2;
    localparam logic [3:0] S_ST2    = 4'd3;
    localparam logic [3:0] S_ST3    = 4'd4;
    localparam logic [3:0] S_FHEAD  = 4'd5;
    localparam logic [3:0] S_FHEADW = 4'd6;
    localparam logic [3:0] S_FNF    = 4'd7;
    localparam logic [3:0] S_FWALK  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = (i_sts.in_fetch == FUNC_FETCH) ? S_FHEAD : S_ST1;
                end
            end
            S_ST1: begin
                if (!i_sts.st_ok) begin
                    n_state = S_IDLE;
                end else if (i_sts.elem_min) begin
                    cmd.run_restart = 1'b1;
                    n_state         = S_ST2;
                end else if (i_sts.run_full) begin
                    n_state = S_IDLE;
                end else if (i_sts.dist_diff) begin
                    cmd.put_prev = 1'b1;
                    n_state      = (i_sts.su_full || i_sts.su_last) ? S_IDLE : S_ST2;
                end else begin
                    n_state = S_ST2;
                end
            end
            S_ST2: begin
                cmd.set_prev = 1'b1;
                if (i_sts.elem_full) begin
                    cmd.put_cur = 1'b1;
                    n_state     = (i_sts.su_full || i_sts.su_last) ? S_IDLE : S_ST3;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ST3: begin
                cmd.wr_last_len = 1'b1;
                n_state         = S_IDLE;
            end
            S_FHEAD: begin
                if (!i_sts.pos_ok) begin
                    cmd.clr_max = 1'b1;
                    n_state     = S_FNF;
                end else begin
                    cmd.rd_head = 1'b1;
                    n_state     = S_FHEADW;
                end
            end
            S_FHEADW: begin
                cmd.latch_max = 1'b1;
                if (i_sts.head_nf) begin
                    n_state = S_FNF;
                end else begin
                    cmd.rd_first = 1'b1;
                    n_state      = S_FWALK;
                end
            end
            S_FNF: begin
                if (i_sts.out_free) begin
                    cmd.load_nf = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FWALK: begin
                if (i_sts.out_free) begin
                    cmd.load_run = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.walk_adv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: src/mlrc_dp.sv
module mlrc_dp #(
    parameter int POSITIONS = mlrc_pkg::DEF_POSITIONS,
    parameter int SLOTS     = mlrc_pkg::DEF_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mlrc_pkg::t_cmd                i_cmd,
    output mlrc_pkg::t_sts                o_sts,
    input  logic                          i_func,
    input  logic [mlrc_pkg::POS_W-1:0]    i_pos,
    input  logic [mlrc_pkg::LEN_W-1:0]    i_full_len,
    input  logic [mlrc_pkg::LEN_W-1:0]    i_elem_len,
    input  logic [mlrc_pkg::DIST_W-1:0]   i_elem_dist,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic [mlrc_pkg::LEN_W-1:0]    o_run_start,
    output logic [mlrc_pkg::LEN_W-1:0]    o_run_end,
    output logic [mlrc_pkg::DIST_W-1:0]   o_run_dist,
    output logic [mlrc_pkg::LEN_W-1:0]    o_max_cached,
    output logic                          o_last_run
);
    import mlrc_pkg::*;

    `include "match_length_run_cache_unit_macros.svh"

    localparam int DEPTH = POSITIONS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUW   = $clog2(SLOTS + 1);
    localparam int PCW   = ($clog2(POSITIONS + 1) > POS_W) ? $clog2(POSITIONS + 1) : POS_W;

    // run store split into length byte and distance
    logic [BYTE_W-1:0] mem_len  [DEPTH];
    logic [DIST_W-1:0] mem_dist [DEPTH];

    logic [POS_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_full;
    logic [LEN_W-1:0]  r_elem;
    logic [DIST_W-1:0] r_dist;

    logic [DIST_W-1:0] r_prev;
    logic [SUW-1:0]    r_su;
    logic              r_rf;

    logic [AW-1:0]     r_clr_addr;
    logic [BYTE_W-1:0] r_rd_len;
    logic [DIST_W-1:0] r_rd_dist;
    logic [LEN_W-1:0]  r_max;
    logic [SW-1:0]     r_slot;
    logic [LEN_W-1:0]  r_prevlen;

    logic              r_out_valid;
    logic              r_o_found;
    logic [LEN_W-1:0]  r_o_start;
    logic [LEN_W-1:0]  r_o_end;
    logic [DIST_W-1:0] r_o_dist;
    logic [LEN_W-1:0]  r_o_max;
    logic              r_o_last;

    logic [AW-1:0]     base;
    logic [AW-1:0]     last_addr;
    logic [AW-1:0]     su_addr;
    logic [SW-1:0]     slot_nxt;
    logic [AW-1:0]     walk_addr;
    logic              su_full;
    logic              su_last;
    logic              wr_en;
    logic              wr_dist_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_len;
    logic [DIST_W-1:0] wr_dist;
    logic              rd_en;
    logic [AW-1:0]     rd_len_addr;
    logic [AW-1:0]     rd_dist_addr;
    logic [LEN_W-1:0]  head_max;
    logic [LEN_W-1:0]  run_end;
    logic              out_free;
    logic              walk_last;

    assign base      = AW'(AW'(r_pos) * AW'(SLOTS));
    assign last_addr = base + AW'(SLOTS - 1);
    assign su_addr   = base + AW'(r_su);
    assign slot_nxt  = r_slot + 1'b1;
    assign walk_addr = base + AW'(slot_nxt);

    assign su_full = (r_su >= SUW'(SLOTS));
    assign su_last = (r_su == SUW'(SLOTS - 1));

    assign head_max  = (r_rd_dist != '0) ? ({1'b0, r_rd_len} + MIN_LEN) : '0;
    assign run_end   = {1'b0, r_rd_len} + MIN_LEN;
    assign walk_last = (run_end == r_max) || (r_slot == SW'(SLOTS - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    // memory write side: clearing pass, run writes, last length byte
    always_comb begin
        wr_en      = i_cmd.clr_wr || i_cmd.wr_last_len
                     || ((i_cmd.put_prev || i_cmd.put_cur) && !su_full);
        wr_dist_en = !i_cmd.wr_last_len;
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_addr;
            wr_len  = '0;
            wr_dist = '0;
        end else if (i_cmd.wr_last_len) begin
            wr_addr = last_addr;
            wr_len  = BYTE_W'(r_full - MIN_LEN);
            wr_dist = r_dist;
        end else if (i_cmd.put_prev) begin
            wr_addr = su_addr;
            wr_len  = BYTE_W'(r_elem - MIN_LEN - 1'b1);
            wr_dist = r_prev;
        end else begin
            wr_addr = su_addr;
            wr_len  = BYTE_W'(r_elem - MIN_LEN);
            wr_dist = r_dist;
        end
    end

    // memory read side: head pair, then one slot per step
    always_comb begin
        rd_en = i_cmd.rd_head || i_cmd.rd_first || i_cmd.walk_adv;
        if (i_cmd.rd_head) begin
            rd_len_addr  = last_addr;
            rd_dist_addr = base;
        end else if (i_cmd.walk_adv) begin
            rd_len_addr  = walk_addr;
            rd_dist_addr = walk_addr;
        end else begin
            rd_len_addr  = base;
            rd_dist_addr = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_len[wr_addr] <= wr_len;
        end
        if (wr_en && wr_dist_en) begin
            mem_dist[wr_addr] <= wr_dist;
        end
        if (rd_en) begin
            r_rd_len  <= mem_len[rd_len_addr];
            r_rd_dist <= mem_dist[rd_dist_addr];
        end
    end

    // captured request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos  <= i_pos;
            r_full <= i_full_len;
            r_elem <= i_elem_len;
            r_dist <= i_elem_dist;
        end
        if (i_cmd.clr_max) begin
            r_max <= '0;
        end else if (i_cmd.latch_max) begin
            r_max <= head_max;
        end
        if (i_cmd.rd_first) begin
            r_slot    <= '0;
            r_prevlen <= '0;
        end else if (i_cmd.walk_adv) begin
            r_slot    <= slot_nxt;
            r_prevlen <= run_end + 1'b1;
        end
    end

    // store run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_su       <= '0;
            r_rf       <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.set_prev) begin
                r_prev <= r_dist;
            end
            if (i_cmd.run_restart) begin
                r_su <= '0;
                r_rf <= 1'b0;
            end else if (i_cmd.put_prev || i_cmd.put_cur) begin
                if (!su_full) begin
                    r_su <= r_su + 1'b1;
                end
                if (su_full || su_last || i_cmd.put_cur) begin
                    r_rf <= 1'b1;
                end
            end else if (i_cmd.wr_last_len) begin
                r_rf <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_nf || i_cmd.load_run) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_nf) begin
            r_o_found <= 1'b0;
            r_o_start <= '0;
            r_o_end   <= '0;
            r_o_dist  <= '0;
            r_o_max   <= r_max;
            r_o_last  <= 1'b1;
        end else if (i_cmd.load_run) begin
            r_o_found <= 1'b1;
            r_o_start <= r_prevlen;
            r_o_end   <= run_end;
            r_o_dist  <= r_rd_dist;
            r_o_max   <= r_max;
            r_o_last  <= walk_last;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = (r_clr_addr == AW'(DEPTH - 1));
        o_sts.in_fetch  = i_func;
        o_sts.pos_ok    = (PCW'(r_pos) < PCW'(POSITIONS));
        o_sts.st_ok     = (PCW'(r_pos) < PCW'(POSITIONS)) && (r_full >= MIN_LEN)
                          && (r_elem >= MIN_LEN) && (r_elem <= r_full);
        o_sts.elem_min  = (r_elem == MIN_LEN);
        o_sts.elem_full = (r_elem == r_full);
        o_sts.dist_diff = (r_dist != r_prev);
        o_sts.run_full  = r_rf;
        o_sts.su_full   = su_full;
        o_sts.su_last   = su_last;
        o_sts.head_nf   = (r_full < MIN_LEN) || (head_max == '0);
        o_sts.walk_last = walk_last;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_o_found;
    assign o_run_start  = r_o_start;
    assign o_run_end    = r_o_end;
    assign o_run_dist   = r_o_dist;
    assign o_max_cached = r_o_max;
    assign o_last_run   = r_o_last;

    `MLRC_ASSERT_IMP(a_full_slots_close_run, i_clk, i_rst_n, r_su == SUW'(SLOTS), r_rf)
    `MLRC_ASSERT_IMP(a_walk_in_slots, i_clk, i_rst_n, i_cmd.walk_adv,
        r_slot != SW'(SLOTS - 1))
    `MLRC_ASSERT_IMP(a_not_found_is_last, i_clk, i_rst_n, r_out_valid && !r_o_found,
        r_o_last)
    `MLRC_ASSERT_IMP(a_no_rd_wr_mix, i_clk, i_rst_n, wr_en, !rd_en)

endmodule

// File: src/match_length_run_cache_unit.sv
// match length run cache: keeps, per position, the best match distance for
// every match length as up to SLOTS runs of (end length minus 3, distance).
// a store request (func 0) carries one element of a run, lengths ascending
// from 3 to full_len; equal neighboring distances fold into one run, and
// when fewer than SLOTS runs are used the last slot's length is set to the
// full length. a store gives no result; from accept to the next accept it
// steps through a check state that may close the previous run, a state
// that records the distance and may write the final run, a state for the
// last-slot length byte, then the idle state that takes the next request;
// an ignored element, or one whose closing write fills the slots, ends
// after the check state.
// a fetch request (func 1) gives one result per cached run, last_run on the
// final one, each with max_cached; an empty position, an out-of-range pos or
// full_len below 3 gives a single result with found low. a fetch reads
// the head pair and latches max_cached, then gives its results as the
// single read port of the run store walks one slot per cycle while the
// output is not stalled; an out-of-range pos skips the head read.
// results sit in an output register, so a new request is taken while the
// last result still waits. after reset a clearing pass zeroes all
// POSITIONS*SLOTS entries of the store, one entry per cycle; o_in_stall
// stays high meanwhile.
module match_length_run_cache_unit #(
    parameter int POSITIONS = mlrc_pkg::DEF_POSITIONS,
    parameter int SLOTS     = mlrc_pkg::DEF_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [mlrc_pkg::POS_W-1:0]    i_pos,
    input  logic [mlrc_pkg::LEN_W-1:0]    i_full_len,
    input  logic [mlrc_pkg::LEN_W-1:0]    i_elem_len,
    input  logic [mlrc_pkg::DIST_W-1:0]   i_elem_dist,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [mlrc_pkg::LEN_W-1:0]    o_run_start,
    output logic [mlrc_pkg::LEN_W-1:0]    o_run_end,
    output logic [mlrc_pkg::DIST_W-1:0]   o_run_dist,
    output logic [mlrc_pkg::LEN_W-1:0]    o_max_cached,
    output logic                          o_last_run
);
    import mlrc_pkg::*;

    // commands from the sequencer, flags back from the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clearing pass, store steps, fetch walk
    mlrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // run store memories, run state, output register
    mlrc_dp #(
        .POSITIONS (POSITIONS),
        .SLOTS     (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_pos        (i_pos),
        .i_full_len   (i_full_len),
        .i_elem_len   (i_elem_len),
        .i_elem_dist  (i_elem_dist),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_run_start  (o_run_start),
        .o_run_end    (o_run_end),
        .o_run_dist   (o_run_dist),
        .o_max_cached (o_max_cached),
        .o_last_run   (o_last_run)
    );

endmodule
